// File: src/rx_line_assembly_ring_top_macros.svh
// ---------------------------------------------------------------------------
// rx_line_assembly_ring_top_macros.svh
// Assertion macros for the line assembly ring checker. Clock is clk,
// synchronous reset is rst.
// ---------------------------------------------------------------------------
`ifndef RX_LINE_ASSEMBLY_RING_TOP_MACROS_SVH
`define RX_LINE_ASSEMBLY_RING_TOP_MACROS_SVH

// same-cycle implication
`define RLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rla_pkg.sv
// ---------------------------------------------------------------------------
// rla_pkg
// Shared constants, status codes and interface structs of the receive line
// assembly ring.
// ---------------------------------------------------------------------------
package rla_pkg;

  localparam int LINE_SLOTS  = 4;
  localparam int LINE_LENGTH = 32;

  localparam int SLOT_W    = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
  localparam int POS_W     = $clog2(LINE_LENGTH);
  localparam int LEN_W     = $clog2(LINE_LENGTH + 1);
  localparam int CNT_W     = $clog2(LINE_SLOTS + 1);
  localparam int ADDR_W    = SLOT_W + POS_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic [7:0] CH_CR          = 8'd13;
  localparam logic [7:0] CH_LF          = 8'd10;
  localparam logic [7:0] EXTRA_TERM_RST = 8'd33;

  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_STORED,
    ST_LINE_DONE,
    ST_TERM_ABSORBED,
    ST_ZERO_IGNORED,
    ST_NO_SLOT,
    ST_TOO_LONG,
    ST_READ_BYTE,
    ST_READ_EMPTY
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic    valid;
    logic    from_mem;
    status_t status;
    logic    last;
  } res_ctl_t;

endpackage

// File: src/rla_line_mem.sv
// ---------------------------------------------------------------------------
// rla_line_mem
// Line slot byte store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rla_line_mem (
  input  logic              clk,
  input  rla_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);
  import rla_pkg::*;

  logic [7:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// File: src/rla_ctrl.sv
// ---------------------------------------------------------------------------
// rla_ctrl
// Slot bookkeeping, receive decisions and the line read-out sequencer.
// ---------------------------------------------------------------------------
module rla_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     kind,
  input  logic [7:0]               rx_byte,
  input  logic                     cfg_we,
  input  logic [7:0]               cfg_wdata,
  output logic                     busy,
  output rla_pkg::mem_req_t        mem_req,
  output rla_pkg::res_ctl_t        res_ctl,
  output logic [rla_pkg::CNT_W-1:0] lines_ready,
  output logic [rla_pkg::CNT_W-1:0] free_slots
);
  import rla_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LF_WRITE, S_READ} state_t;

  state_t              state;
  logic [7:0]          extra_term;
  logic [SLOT_W-1:0]   write_slot;
  logic [SLOT_W-1:0]   read_slot;
  logic [CNT_W-1:0]    complete;
  logic [CNT_W-1:0]    unclaimed;
  logic [POS_W-1:0]    wpos;
  logic [7:0]          prev_byte;
  logic [ADDR_W-1:0]   lf_addr;
  logic [SLOT_W-1:0]   rd_slot;
  logic [POS_W-1:0]    rd_idx;
  logic [LEN_W-1:0]    rd_len;
  logic                res_valid;
  status_t             res_status;
  logic                rd_pend;
  logic                rd_plast;
  logic [LEN_W-1:0]    line_len [LINE_SLOTS];

  logic                accept;
  logic                is_term;
  logic                wp_zero;
  logic                too_long;
  logic                prev_crlf;
  status_t             rx_status;
  logic                rx_store;
  logic                rd_is_last;
  logic [POS_W:0]      rd_idx_inc;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(LINE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign accept     = start && (state == S_IDLE);
  assign is_term    = (rx_byte == CH_CR) || (rx_byte == CH_LF) || (rx_byte == extra_term);
  assign wp_zero    = (wpos == '0);
  assign too_long   = ({2'b00, wpos} + (POS_W + 2)'(2)) >= (POS_W + 2)'(LINE_LENGTH);
  assign prev_crlf  = (prev_byte == CH_CR) || (prev_byte == CH_LF);
  assign rd_idx_inc = {1'b0, rd_idx} + 1'b1;
  assign rd_is_last = (rd_idx_inc == (POS_W + 1)'(rd_len));

  always_comb begin
    if (rx_byte == 8'd0) begin
      rx_status = ST_ZERO_IGNORED;
    end else if (wp_zero && (unclaimed == '0)) begin
      rx_status = ST_NO_SLOT;
    end else if (!is_term && too_long) begin
      rx_status = ST_TOO_LONG;
    end else if (is_term) begin
      rx_status = prev_crlf ? ST_TERM_ABSORBED : ST_LINE_DONE;
    end else begin
      rx_status = ST_STORED;
    end
  end

  assign rx_store = (rx_status == ST_STORED) || (rx_status == ST_LINE_DONE) ||
                    (rx_status == ST_TERM_ABSORBED);

  always_comb begin
    mem_req.we    = (accept && (kind == KIND_RX) && rx_store) || (state == S_LF_WRITE);
    mem_req.waddr = (state == S_LF_WRITE) ? lf_addr : {write_slot, wpos};
    mem_req.wdata = (state == S_LF_WRITE) ? CH_LF : rx_byte;
    mem_req.re    = (state == S_READ);
    mem_req.raddr = {rd_slot, rd_idx};
  end

  always_comb begin
    res_ctl.valid    = res_valid || rd_pend;
    res_ctl.from_mem = rd_pend;
    res_ctl.status   = rd_pend ? ST_READ_BYTE : res_status;
    res_ctl.last     = rd_pend ? rd_plast : 1'b1;
  end

  assign busy        = (state != S_IDLE);
  assign lines_ready = complete;
  assign free_slots  = unclaimed;

  // line lengths per slot, written when a line closes
  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_RX) && (rx_status == ST_LINE_DONE)) begin
      line_len[write_slot] <= LEN_W'({1'b0, wpos} + (POS_W + 1)'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      extra_term <= EXTRA_TERM_RST;
      write_slot <= '0;
      read_slot  <= '0;
      complete   <= '0;
      unclaimed  <= CNT_W'(LINE_SLOTS);
      wpos       <= '0;
      prev_byte  <= '0;
      res_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      rd_pend   <= 1'b0;
      if (cfg_we) begin
        extra_term <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_READ) begin
              if (complete == '0) begin
                res_valid  <= 1'b1;
                res_status <= ST_READ_EMPTY;
              end else begin
                rd_slot   <= read_slot;
                rd_len    <= line_len[read_slot];
                rd_idx    <= '0;
                read_slot <= next_slot(read_slot);
                complete  <= complete - 1'b1;
                unclaimed <= unclaimed + 1'b1;
                state     <= S_READ;
              end
            end else begin
              res_valid  <= 1'b1;
              res_status <= rx_status;
              if (rx_store) begin
                prev_byte <= rx_byte;
              end
              case (rx_status)
                ST_LINE_DONE: begin
                  if (wp_zero) begin
                    unclaimed <= unclaimed - 1'b1;
                  end
                  lf_addr    <= {write_slot, wpos + 1'b1};
                  write_slot <= next_slot(write_slot);
                  complete   <= complete + 1'b1;
                  wpos       <= '0;
                  state      <= S_LF_WRITE;
                end
                ST_TERM_ABSORBED: begin
                  if (!wp_zero) begin
                    unclaimed <= unclaimed + 1'b1;
                  end
                  wpos <= '0;
                end
                ST_STORED: begin
                  if (wp_zero) begin
                    unclaimed <= unclaimed - 1'b1;
                  end
                  wpos <= wpos + 1'b1;
                end
                default: begin
                end
              endcase
            end
          end
        end
        S_LF_WRITE: begin
          state <= S_IDLE;
        end
        S_READ: begin
          rd_pend  <= 1'b1;
          rd_plast <= rd_is_last;
          if (rd_is_last) begin
            state <= S_IDLE;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/rx_line_assembly_ring_top.sv
// ---------------------------------------------------------------------------
// rx_line_assembly_ring_top
// Receive line assembly into a ring of line slots with line read-out.
// ---------------------------------------------------------------------------
// Receive item: result in the cycle after accept; busy is raised only for the
//   LF write when a line closes (through the single store write port).
// Read item: first byte after the S_READ state and the registered store read,
//   then one byte per cycle from the store read port; busy for the S_READ state.
// Empty read: one result in the cycle after accept.
// Synchronous reset clears counters and pointers; the byte store is not cleared.
module rx_line_assembly_ring_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic [7:0]                rx_byte,
  input  logic                      cfg_we,
  input  logic [7:0]                cfg_wdata,
  output logic                      strobe,
  output logic [2:0]                status,
  output logic [7:0]                data_byte,
  output logic                      last,
  output logic [rla_pkg::CNT_W-1:0] lines_ready,
  output logic [rla_pkg::CNT_W-1:0] free_slots
);
  import rla_pkg::*;

  mem_req_t   mem_req;
  res_ctl_t   res_ctl;
  logic [7:0] mem_q;

  rla_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .kind        (kind),
    .rx_byte     (rx_byte),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .busy        (busy),
    .mem_req     (mem_req),
    .res_ctl     (res_ctl),
    .lines_ready (lines_ready),
    .free_slots  (free_slots)
  );

  rla_line_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_q)
  );

  assign strobe    = res_ctl.valid;
  assign status    = res_ctl.status;
  assign last      = res_ctl.last;
  assign data_byte = res_ctl.from_mem ? mem_q : 8'd0;

endmodule

// File: src/rla_checker.sv
// ---------------------------------------------------------------------------
// rla_checker
// Port-level checks of the line assembly ring, bound to the top level.
// ---------------------------------------------------------------------------
`include "rx_line_assembly_ring_top_macros.svh"

module rla_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      kind,
  input logic                      strobe,
  input logic [2:0]                status,
  input logic [7:0]                data_byte,
  input logic                      last,
  input logic [rla_pkg::CNT_W-1:0] lines_ready,
  input logic [rla_pkg::CNT_W-1:0] free_slots
);
  import rla_pkg::*;

  logic           rx_take;
  logic           rd_take;
  logic           empty_res;
  logic           plain_res;
  logic [CNT_W:0] slot_sum;

  assign rx_take   = start && !busy && (kind == KIND_RX);
  assign rd_take   = start && !busy && (kind == KIND_READ);
  assign empty_res = strobe && (status == ST_READ_EMPTY);
  assign plain_res = strobe && (status != ST_READ_BYTE);
  assign slot_sum  = {1'b0, lines_ready} + {1'b0, free_slots};

  `RLA_ASSERT_IMP(a_slot_sum, 1'b1, slot_sum <= (CNT_W + 1)'(LINE_SLOTS), "ring overfull")
  `RLA_ASSERT_NEXT(a_rx_result, rx_take, strobe && last, "receive item gave no single result")
  `RLA_ASSERT_NEXT(a_read_progress, rd_take, busy || strobe, "read item stalled")
  `RLA_ASSERT_IMP(a_empty_read, empty_res, lines_ready == '0, "empty read with lines queued")
  `RLA_ASSERT_IMP(a_data_zero, plain_res, data_byte == 8'd0, "data on a non-read result")

endmodule

bind rx_line_assembly_ring_top rla_checker u_rla_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .kind        (kind),
  .strobe      (strobe),
  .status      (status),
  .data_byte   (data_byte),
  .last        (last),
  .lines_ready (lines_ready),
  .free_slots  (free_slots)
);
